>>> src/trisol_pkg.sv
// Shared constants, types and fixed-point helpers for the tridiagonal solver.
package trisol_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int IDX_W     = 6;
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int DIV_W     = Q_W + FRAC_BITS;
    localparam int DIV_CW    = $clog2(DIV_W + 1);
    localparam int ROW_W     = 2 * Q_W;

    typedef logic signed [Q_W-1:0]   t_q;
    typedef logic signed [2*Q_W-1:0] t_prod;

    localparam t_q Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Saturating subtract a - b
    function automatic t_q sat_sub(input t_q a, input t_q b);
        logic signed [Q_W:0] d;
        d = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (d[Q_W] != d[Q_W-1]) begin
            return d[Q_W] ? Q_MIN : Q_MAX;
        end
        return d[Q_W-1:0];
    endfunction

    // Scale a full product back to Q format, rounding toward zero, saturating
    function automatic t_q prod_to_q(input t_prod p);
        logic             neg;
        logic [2*Q_W-1:0] mag;
        logic [2*Q_W-1:0] sh;
        logic [Q_W-1:0]   lo;
        neg = p[2*Q_W-1];
        mag = neg ? (2*Q_W)'(-p) : (2*Q_W)'(p);
        sh  = mag >> FRAC_BITS;
        lo  = sh[Q_W-1:0];
        if (!neg) begin
            return (sh > (2*Q_W)'(Q_MAX)) ? Q_MAX : t_q'(lo);
        end
        if (sh > {{Q_W{1'b0}}, 1'b1, {(Q_W-1){1'b0}}}) begin
            return Q_MIN;
        end
        return t_q'(-lo);
    endfunction

endpackage

>>> src/trisol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trisol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/tridiagonal_solver.sv
// Top level of the Thomas-algorithm tridiagonal solver in signed Q16.16.
// Rows are loaded one word per cycle with start; a row with i_last_row set
// starts the solve and busy stays high until the last unknown is out. Every
// row after the first passes once through the shared serial divider in
// elimination, and every row passes once in back substitution, one quotient
// bit per cycle; the dividend is DIV_W = 48 bits wide for Q16.16.
// Unknowns leave in index order, each on o_valid for a single cycle; they
// cannot be held off and must be taken as shown.
module tridiagonal_solver (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  trisol_pkg::t_q          i_sub_coef,
    input  trisol_pkg::t_q          i_main_coef,
    input  trisol_pkg::t_q          i_super_coef,
    input  trisol_pkg::t_q          i_rhs_value,
    input  logic                    i_last_row,
    output logic                    o_valid,
    output trisol_pkg::t_q          o_solution_value,
    output logic [trisol_pkg::IDX_W-1:0] o_solution_index,
    output logic                    o_last_value,
    output logic                    o_singular
);
    import trisol_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_INIT_CAP = 4'd2;
    localparam logic [3:0] S_E_RD     = 4'd3;
    localparam logic [3:0] S_E_CAP    = 4'd4;
    localparam logic [3:0] S_E_DIV    = 4'd5;
    localparam logic [3:0] S_E_MUL1   = 4'd6;
    localparam logic [3:0] S_E_SUB1   = 4'd7;
    localparam logic [3:0] S_E_MUL2   = 4'd8;
    localparam logic [3:0] S_E_SUB2   = 4'd9;
    localparam logic [3:0] S_B_DIV    = 4'd10;
    localparam logic [3:0] S_B_RD     = 4'd11;
    localparam logic [3:0] S_B_CAP    = 4'd12;
    localparam logic [3:0] S_B_SUB    = 4'd13;
    localparam logic [3:0] S_B_GO     = 4'd14;
    localparam logic [3:0] S_O_WR     = 4'd15;

    logic [3:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [ROW_AW-1:0] r_last;
    logic [ROW_AW-1:0] r_i;
    logic              r_singular;
    logic              r_out_rd;
    t_q r_dprev, r_rprev, r_sup_prev, r_sup_cur, r_dcur, r_rcur, r_m, r_xnext;
    t_prod r_prod;

    // Row memories: A holds {sub, super}, B holds {diag, rhs} and later x
    logic              a_we, b_we;
    logic [ROW_AW-1:0] a_waddr, b_waddr, raddr;
    logic [ROW_W-1:0]  a_wdata, b_wdata, a_rdata, b_rdata;
    t_q a_sub, a_super, b_diag, b_rhs;

    // Divider
    logic              dv_go, dv_done;
    t_q                dv_a, dv_b, dv_q;
    logic              r_dv_run, r_dv_neg, r_dv_zero, r_dv_aneg;
    logic [DIV_CW-1:0] r_dv_cnt;
    logic [DIV_W-1:0]  r_dv_dvd;
    logic [Q_W-1:0]    r_dv_rem, r_dv_dsr;
    logic [Q_W:0]      dv_rem_sh;
    logic              dv_bit;

    logic              accept, full;
    logic [ROW_AW-1:0] slot;
    t_q                e_rnew, b_t;

    assign a_sub   = a_rdata[ROW_W-1:Q_W];
    assign a_super = a_rdata[Q_W-1:0];
    assign b_diag  = b_rdata[ROW_W-1:Q_W];
    assign b_rhs   = b_rdata[Q_W-1:0];

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_cnt == CNT_W'(MAX_ROWS));
    assign slot   = full ? ROW_AW'(MAX_ROWS - 1) : r_cnt[ROW_AW-1:0];
    assign e_rnew = sat_sub(r_rcur, prod_to_q(r_prod));
    assign b_t    = sat_sub(r_rcur, prod_to_q(r_prod));

    trisol_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_waddr(a_waddr),
        .i_wdata(a_wdata),
        .i_raddr(raddr),
        .o_rdata(a_rdata)
    );

    trisol_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(b_waddr),
        .i_wdata(b_wdata),
        .i_raddr(raddr),
        .o_rdata(b_rdata)
    );

    // Memory write and read selection
    always_comb begin
        a_we    = accept && (!full || i_last_row);
        a_waddr = slot;
        a_wdata = {i_sub_coef, i_super_coef};
        b_we    = a_we;
        b_waddr = slot;
        b_wdata = {i_main_coef, i_rhs_value};
        raddr   = r_i;
        if (r_state == S_E_SUB2) begin
            b_we    = 1'b1;
            b_waddr = r_i;
            b_wdata = {r_dcur, e_rnew};
        end else if (r_state == S_B_DIV) begin
            b_we    = dv_done;
            b_waddr = r_i;
            b_wdata = {dv_q, Q_W'(0)};
        end
        if (r_state == S_INIT) begin
            raddr = '0;
        end
    end

    // Divider launch points
    always_comb begin
        dv_go = 1'b0;
        dv_a  = r_rcur;
        dv_b  = r_dcur;
        unique case (r_state)
            S_INIT_CAP: begin
                dv_go = (r_last == '0);
                dv_a  = b_rhs;
                dv_b  = b_diag;
            end
            S_E_CAP: begin
                dv_go = 1'b1;
                dv_a  = a_sub;
                dv_b  = r_dprev;
            end
            S_E_SUB2: begin
                dv_go = (r_i == r_last);
                dv_a  = e_rnew;
                dv_b  = r_dcur;
            end
            S_B_GO: begin
                dv_go = 1'b1;
            end
            default: begin
                dv_go = 1'b0;
            end
        endcase
    end

    // Serial restoring divider: one quotient bit per cycle
    assign dv_rem_sh = {r_dv_rem, r_dv_dvd[DIV_W-1]};
    assign dv_bit    = (dv_rem_sh >= {1'b0, r_dv_dsr});
    assign dv_done   = r_dv_run && (r_dv_cnt == '0);

    always_comb begin
        if (r_dv_zero) begin
            dv_q = r_dv_aneg ? Q_MIN : Q_MAX;
        end else if (r_dv_neg) begin
            if (r_dv_dvd > DIV_W'({1'b1, {(Q_W-1){1'b0}}})) begin
                dv_q = Q_MIN;
            end else begin
                dv_q = t_q'(-r_dv_dvd[Q_W-1:0]);
            end
        end else if (r_dv_dvd > DIV_W'(Q_MAX)) begin
            dv_q = Q_MAX;
        end else begin
            dv_q = t_q'(r_dv_dvd[Q_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_run <= 1'b0;
        end else if (dv_go) begin
            r_dv_run <= 1'b1;
        end else if (dv_done) begin
            r_dv_run <= 1'b0;
        end
        if (dv_go) begin
            r_dv_cnt  <= DIV_CW'(DIV_W);
            r_dv_dvd  <= {(dv_a[Q_W-1] ? Q_W'(-dv_a) : Q_W'(dv_a)), FRAC_BITS'(0)};
            r_dv_dsr  <= dv_b[Q_W-1] ? Q_W'(-dv_b) : Q_W'(dv_b);
            r_dv_rem  <= '0;
            r_dv_neg  <= dv_a[Q_W-1] ^ dv_b[Q_W-1];
            r_dv_zero <= (dv_b == '0);
            r_dv_aneg <= dv_a[Q_W-1];
        end else if (r_dv_run && r_dv_cnt != '0) begin
            r_dv_cnt <= r_dv_cnt - 1'b1;
            r_dv_dvd <= {r_dv_dvd[DIV_W-2:0], dv_bit};
            r_dv_rem <= dv_bit ? Q_W'(dv_rem_sh - {1'b0, r_dv_dsr}) : dv_rem_sh[Q_W-1:0];
        end
    end

    // Sequencer: load, eliminate, substitute back, stream out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_singular <= 1'b0;
            r_out_rd   <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (dv_done && r_dv_zero) begin
                r_singular <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_last_row) begin
                            r_last     <= slot;
                            r_cnt      <= '0;
                            r_singular <= 1'b0;
                            r_state    <= S_INIT;
                        end else if (!full) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    r_state <= S_INIT_CAP;
                end
                S_INIT_CAP: begin
                    r_dprev    <= b_diag;
                    r_rprev    <= b_rhs;
                    r_sup_prev <= a_super;
                    if (r_last == '0) begin
                        r_i     <= '0;
                        r_state <= S_B_DIV;
                    end else begin
                        r_i     <= ROW_AW'(1);
                        r_state <= S_E_RD;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_CAP;
                end
                S_E_CAP: begin
                    r_sup_cur <= a_super;
                    r_dcur    <= b_diag;
                    r_rcur    <= b_rhs;
                    r_state   <= S_E_DIV;
                end
                S_E_DIV: begin
                    if (dv_done) begin
                        r_m     <= dv_q;
                        r_state <= S_E_MUL1;
                    end
                end
                S_E_MUL1: begin
                    r_prod  <= t_prod'(r_m) * t_prod'(r_sup_prev);
                    r_state <= S_E_SUB1;
                end
                S_E_SUB1: begin
                    r_dcur  <= sat_sub(r_dcur, prod_to_q(r_prod));
                    r_state <= S_E_MUL2;
                end
                S_E_MUL2: begin
                    r_prod  <= t_prod'(r_m) * t_prod'(r_rprev);
                    r_state <= S_E_SUB2;
                end
                S_E_SUB2: begin
                    r_dprev    <= r_dcur;
                    r_rprev    <= e_rnew;
                    r_sup_prev <= r_sup_cur;
                    if (r_i == r_last) begin
                        r_state <= S_B_DIV;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_E_RD;
                    end
                end
                S_B_DIV: begin
                    if (dv_done) begin
                        r_xnext <= dv_q;
                        if (r_i == '0) begin
                            r_out_rd <= 1'b1;
                            r_state  <= S_O_WR;
                        end else begin
                            r_i     <= r_i - 1'b1;
                            r_state <= S_B_RD;
                        end
                    end
                end
                S_B_RD: begin
                    r_state <= S_B_CAP;
                end
                S_B_CAP: begin
                    r_dcur  <= b_diag;
                    r_rcur  <= b_rhs;
                    r_prod  <= t_prod'(a_super) * t_prod'(r_xnext);
                    r_state <= S_B_SUB;
                end
                S_B_SUB: begin
                    r_rcur  <= b_t;
                    r_state <= S_B_GO;
                end
                S_B_GO: begin
                    r_state <= S_B_DIV;
                end
                S_O_WR: begin
                    // Alternate: read cycle, then drive the word
                    r_out_rd <= !r_out_rd;
                    if (!r_out_rd) begin
                        o_valid          <= 1'b1;
                        o_solution_value <= b_diag;
                        o_solution_index <= IDX_W'(r_i);
                        o_last_value     <= (r_i == r_last);
                        o_singular       <= r_singular;
                        if (r_i == r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on sequencing
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> (r_state == S_E_DIV || r_state == S_B_DIV))
        else $error("divider finished outside a wait state");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_O_WR))
        else $error("result word not from the output state");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_value) |=> !o_valid)
        else $error("result word after the last unknown");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ROWS))
        else $error("row count beyond capacity");

endmodule
